[hw/rtl/sha256_byte_stream_hasher_core_assert.svh]
// Assertion macros for the SHA-256 byte stream hasher core.
// Taken in by the core module; holds only macro definitions.
`ifndef SHA256_BYTE_STREAM_HASHER_CORE_ASSERT_SVH
`define SHA256_BYTE_STREAM_HASHER_CORE_ASSERT_SVH

// Implication that must hold on every clock edge out of reset.
`define SHB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define SHB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/shb_pkg.sv]
// Package for the SHA-256 byte stream hasher: state codes, constants, round functions.
// No dependencies.
package shb_pkg;

    localparam int BLOCK_BYTES = 64;
    localparam int PAD_LIMIT   = 56;
    localparam int ROUNDS      = 64;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_LOAD  = 6'b000010,
        ST_ROUND = 6'b000100,
        ST_ADD   = 6'b001000,
        ST_PAD   = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
        rotr = (v >> n) | (v << (32 - n));
    endfunction

    function automatic logic [31:0] small_sig0(input logic [31:0] x);
        small_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sig1(input logic [31:0] x);
        small_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] big_sig0(input logic [31:0] x);
        big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sig1(input logic [31:0] x);
        big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

endpackage

[hw/rtl/sha256_byte_stream_hasher_core.sv]
// Top level of the SHA-256 byte stream hasher: byte buffer, round unit, sequencer.
// Depends on shb_pkg and sha256_byte_stream_hasher_core_assert.svh.
//
// Channel   Direction  Handshake         Payload
// input     in         start / busy      byte_in, has_byte, end_of_message
// result    out        done (one cycle)  digest_part0 .. digest_part3
//
// A byte without an end mark that does not fill the block is just stored; busy stays low.
// A full block then passes through the load, round and add states after the accepting
// edge, with every round done on the single shared round unit.
// An end mark fills the rest of the block with the pad byte and zeros, the length in the
// last block, over one or two padded block passes; the done state then raises done.
// Reset restores the initial hash values and clears the counters at once.
// The result is shown for one cycle under done; the receiver cannot stall it.
`include "sha256_byte_stream_hasher_core_assert.svh"
module sha256_byte_stream_hasher_core
    import shb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  byte_in,
    input  logic        has_byte,
    input  logic        end_of_message,
    output logic        done,
    output logic [63:0] digest_part0,
    output logic [63:0] digest_part1,
    output logic [63:0] digest_part2,
    output logic [63:0] digest_part3
);

    // Control and chaining registers.
    state_t       state_reg;
    logic [31:0]  h_reg [8];
    logic [31:0]  r_reg [8];
    logic [31:0]  w_reg [16];
    logic [5:0]   pend_reg;
    logic [60:0]  len_reg;
    logic [6:0]   cnt_reg;
    logic         final_reg;
    logic         last_reg;
    logic         done_reg;
    // Block buffer as 16 big-endian words; byte 0 of the block is the top byte of word 0.
    logic [31:0]  buf_mem [BLOCK_BYTES / 4];

    logic         accept;
    logic [31:0]  w_new;
    logic [31:0]  t1;
    logic [31:0]  t2;
    logic [63:0]  bit_len;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign bit_len = {len_reg, 3'b000};

    // Shared round unit.
    always_comb
    begin
        w_new = w_reg[0] + small_sig0(w_reg[1]) + w_reg[9] + small_sig1(w_reg[14]);
        t1 = r_reg[7] + big_sig1(r_reg[4]) + ((r_reg[4] & r_reg[5]) ^ (~r_reg[4] & r_reg[6]))
             + ROUND_K[cnt_reg[5:0]] + w_reg[0];
        t2 = big_sig0(r_reg[0]) + ((r_reg[0] & r_reg[1]) ^ (r_reg[0] & r_reg[2])
             ^ (r_reg[1] & r_reg[2]));
    end

    // Byte buffer writes: message bytes, the pad byte and zero fill.
    always_ff @(posedge clk)
    begin
        if (accept && has_byte)
        begin
            buf_mem[pend_reg[5:2]][{~pend_reg[1:0], 3'b000} +: 8] <= byte_in;
        end
        else if (state_reg == ST_PAD)
        begin
            buf_mem[cnt_reg[5:2]][{~cnt_reg[1:0], 3'b000} +: 8] <=
                (final_reg && cnt_reg[5:0] == pend_reg) ? PAD_BYTE : 8'h00;
        end
    end

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pend_reg  <= '0;
            len_reg   <= '0;
            cnt_reg   <= '0;
            final_reg <= 1'b0;
            last_reg  <= 1'b0;
            done_reg  <= 1'b0;
            digest_part0 <= '0;
            digest_part1 <= '0;
            digest_part2 <= '0;
            digest_part3 <= '0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= INIT_H[i];
                r_reg[i] <= '0;
            end
            for (int i = 0; i < 16; i++)
            begin
                w_reg[i] <= '0;
            end
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (has_byte)
                        begin
                            pend_reg <= pend_reg + 6'd1;
                            len_reg  <= len_reg + 61'd1;
                        end
                        final_reg <= end_of_message;
                        last_reg  <= 1'b0;
                        cnt_reg   <= '0;
                        if (has_byte && pend_reg == 6'(BLOCK_BYTES - 1))
                        begin
                            state_reg <= ST_LOAD;
                        end
                        else if (end_of_message)
                        begin
                            // Start padding at the first free byte.
                            cnt_reg   <= {1'b0, pend_reg + 6'(has_byte)};
                            state_reg <= ST_PAD;
                        end
                    end
                end
                ST_PAD:
                begin
                    // Pad byte, then zeros to the end of the block.
                    cnt_reg <= cnt_reg + 7'd1;
                    if (cnt_reg[5:0] == 6'(BLOCK_BYTES - 1))
                    begin
                        // The extra block already carries last_reg and keeps it.
                        if (final_reg && !last_reg && pend_reg >= 6'(PAD_LIMIT))
                        begin
                            last_reg <= 1'b0;
                        end
                        else
                        begin
                            last_reg <= 1'b1;
                        end
                        cnt_reg   <= '0;
                        state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD:
                begin
                    // The last block of a message carries the bit count in its final two words.
                    if (final_reg && last_reg && cnt_reg[3:0] == 4'd14)
                    begin
                        w_reg[cnt_reg[3:0]] <= bit_len[63:32];
                    end
                    else if (final_reg && last_reg && cnt_reg[3:0] == 4'd15)
                    begin
                        w_reg[cnt_reg[3:0]] <= bit_len[31:0];
                    end
                    else
                    begin
                        w_reg[cnt_reg[3:0]] <= buf_mem[cnt_reg[3:0]];
                    end
                    cnt_reg <= cnt_reg + 7'd1;
                    if (cnt_reg[3:0] == 4'd15)
                    begin
                        cnt_reg <= '0;
                        for (int i = 0; i < 8; i++)
                        begin
                            r_reg[i] <= h_reg[i];
                        end
                        state_reg <= ST_ROUND;
                    end
                end
                ST_ROUND:
                begin
                    r_reg[7] <= r_reg[6];
                    r_reg[6] <= r_reg[5];
                    r_reg[5] <= r_reg[4];
                    r_reg[4] <= r_reg[3] + t1;
                    r_reg[3] <= r_reg[2];
                    r_reg[2] <= r_reg[1];
                    r_reg[1] <= r_reg[0];
                    r_reg[0] <= t1 + t2;
                    for (int i = 0; i < 15; i++)
                    begin
                        w_reg[i] <= w_reg[i + 1];
                    end
                    w_reg[15] <= w_new;
                    cnt_reg <= cnt_reg + 7'd1;
                    if (cnt_reg == 7'(ROUNDS - 1))
                    begin
                        state_reg <= ST_ADD;
                    end
                end
                ST_ADD:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        h_reg[i] <= h_reg[i] + r_reg[i];
                    end
                    cnt_reg <= '0;
                    if (!final_reg)
                    begin
                        pend_reg  <= '0;
                        state_reg <= ST_IDLE;
                    end
                    else if (last_reg)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else if (pend_reg == 6'd0)
                    begin
                        // A full block ended the message: pad a fresh block.
                        cnt_reg   <= '0;
                        state_reg <= ST_PAD;
                    end
                    else
                    begin
                        // Extra block: zeros only, then the length.
                        pend_reg  <= 6'(BLOCK_BYTES - 1);
                        final_reg <= 1'b1;
                        cnt_reg   <= '0;
                        last_reg  <= 1'b1;
                        state_reg <= ST_PAD;
                    end
                end
                ST_DONE:
                begin
                    done_reg  <= 1'b1;
                    digest_part0 <= {h_reg[0], h_reg[1]};
                    digest_part1 <= {h_reg[2], h_reg[3]};
                    digest_part2 <= {h_reg[4], h_reg[5]};
                    digest_part3 <= {h_reg[6], h_reg[7]};
                    for (int i = 0; i < 8; i++)
                    begin
                        h_reg[i] <= INIT_H[i];
                    end
                    pend_reg  <= '0;
                    len_reg   <= '0;
                    final_reg <= 1'b0;
                    last_reg  <= 1'b0;
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Assertions.
    `SHB_ASSERT_NEXT(a_done_one_cycle, clk, rst_n, done_reg, !done_reg,
                     "done held for more than one cycle")
    `SHB_ASSERT_NEXT(a_done_after_finish, clk, rst_n, state_reg == ST_DONE,
                     done_reg && state_reg == ST_IDLE, "result not shown after finish")
    `SHB_ASSERT_IMP(a_done_only_final, clk, rst_n, state_reg == ST_DONE,
                    final_reg && last_reg, "finish without a final length block")
    `SHB_ASSERT_IMP(a_round_count, clk, rst_n, state_reg == ST_ROUND,
                    cnt_reg < 7'(ROUNDS), "round counter out of range")

endmodule
